// ----- rtl/rgb_point_color_ops_defines.svh -----
// Assertion helpers for the color operation pipeline.
`ifndef RGB_POINT_COLOR_OPS_DEFINES_SVH
`define RGB_POINT_COLOR_OPS_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RGBCO_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgb_point_color_ops: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define RGBCO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgb_point_color_ops: next-cycle check failed");

`endif

// ----- rtl/rgbco_pkg.sv -----
`default_nettype none
package rgbco_pkg;

   // Q3.12 unity and 16-bit saturation limits
   localparam logic signed [16:0] ONE_Q12   = 17'sd4096;
   localparam logic signed [15:0] ONE_PX    = 16'sd4096;
   localparam logic signed [15:0] ZERO_PX   = 16'sd0;
   localparam logic signed [15:0] PX_MAX    = 16'sd32767;
   localparam logic signed [15:0] PX_MIN    = -16'sd32768;

   // Filter mode codes
   localparam logic [2:0] MODE_PASS   = 3'd0;
   localparam logic [2:0] MODE_INVERT = 3'd1;
   localparam logic [2:0] MODE_THRESH = 3'd2;
   localparam logic [2:0] MODE_SEPIA  = 3'd3;
   localparam logic [2:0] MODE_MIX    = 3'd4;

   // Register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_MODE    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD      = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIX_BG_BALANCE = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIX_INTO_RED   = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIX_RB_BALANCE = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIX_INTO_GREEN = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIX_GR_BALANCE = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIX_INTO_BLUE  = 4'd7;

   localparam logic signed [15:0] THRESHOLD_RESET = 16'sd2048;

   // Luminance weights 0.3 / 0.59 / 0.11 in Q3.12
   localparam logic signed [12:0] LUM_R = 13'sd1229;
   localparam logic signed [12:0] LUM_G = 13'sd2417;
   localparam logic signed [12:0] LUM_B = 13'sd451;

   // Sepia matrix in Q3.12, row = output channel
   localparam logic signed [12:0] SEP_RR = 13'sd1610;
   localparam logic signed [12:0] SEP_RG = 13'sd3150;
   localparam logic signed [12:0] SEP_RB = 13'sd774;
   localparam logic signed [12:0] SEP_GR = 13'sd1430;
   localparam logic signed [12:0] SEP_GG = 13'sd2810;
   localparam logic signed [12:0] SEP_GB = 13'sd688;
   localparam logic signed [12:0] SEP_BR = 13'sd1114;
   localparam logic signed [12:0] SEP_BG = 13'sd2187;
   localparam logic signed [12:0] SEP_BB = 13'sd537;

   // Load enables for the arithmetic stages of one channel lane
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } rgbco_load_type;

endpackage
`default_nettype wire

// ----- rtl/rgbco_lane.sv -----
`default_nettype none
// One color channel: sepia row, invert, passthrough and channel mixer.
// self_px is this channel; p_px and q_px are the two channels blended by the mixer.
module rgbco_lane import rgbco_pkg::*; (
   input  logic                  clock,
   input  rgbco_load_type        ld,
   input  logic [2:0]            mode,
   input  logic signed [15:0]    self_px,
   input  logic signed [15:0]    p_px,
   input  logic signed [15:0]    q_px,
   input  logic signed [12:0]    k_self,
   input  logic signed [12:0]    k_p,
   input  logic signed [12:0]    k_q,
   input  logic signed [15:0]    balance,
   input  logic signed [15:0]    amount,
   output logic signed [15:0]    result
);

   // Stage 2: mixer first products and sepia dot product
   logic signed [16:0] bal_c;
   logic signed [32:0] pb_in, pb_ff;
   logic signed [32:0] qb_in, qb_ff;
   logic signed [29:0] dot_in, dot_ff;
   logic signed [15:0] self2_ff;

   assign bal_c  = ONE_Q12 - {balance[15], balance};
   assign pb_in  = 33'(balance) * 33'(p_px);
   assign qb_in  = 33'(bal_c) * 33'(q_px);
   assign dot_in = 30'(k_self) * 30'(self_px) + 30'(k_p) * 30'(p_px)
                 + 30'(k_q) * 30'(q_px);

   always_ff @(posedge clock) begin
      if (ld.s2) begin
         pb_ff    <= pb_in;
         qb_ff    <= qb_in;
         dot_ff   <= dot_in;
         self2_ff <= self_px;
      end
   end

   // Stage 3: floor-shift the blend, finish the non-mixer modes
   logic signed [33:0] msum;
   logic signed [21:0] m_in, m_ff;
   logic signed [17:0] sep_t;
   logic signed [16:0] inv_v;
   logic signed [15:0] oth_in, oth3_ff, oth4_ff;
   logic signed [15:0] self3_ff;

   assign msum  = 34'(pb_ff) + 34'(qb_ff);
   assign m_in  = msum[33:12];
   assign sep_t = dot_ff[29:12];
   assign inv_v = ONE_Q12 - {self2_ff[15], self2_ff};

   always_comb begin
      case (mode)
         MODE_INVERT: begin
            if (inv_v > 17'(PX_MAX)) oth_in = PX_MAX;
            else oth_in = inv_v[15:0];
         end
         MODE_SEPIA: begin
            if (sep_t > 18'(ONE_PX)) oth_in = ONE_PX;
            else if (sep_t < 18'(PX_MIN)) oth_in = PX_MIN;
            else oth_in = sep_t[15:0];
         end
         default: oth_in = self2_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ld.s3) begin
         m_ff     <= m_in;
         oth3_ff  <= oth_in;
         self3_ff <= self2_ff;
      end
   end

   // Stage 4: mixer second products
   logic signed [16:0] amt_c;
   logic signed [37:0] u_in, u_ff;
   logic signed [32:0] w_in, w_ff;

   assign amt_c = ONE_Q12 - {amount[15], amount};
   assign u_in  = 38'(amount) * 38'(m_ff);
   assign w_in  = 33'(amt_c) * 33'(self3_ff);

   always_ff @(posedge clock) begin
      if (ld.s4) begin
         u_ff    <= u_in;
         w_ff    <= w_in;
         oth4_ff <= oth3_ff;
      end
   end

   // Final sum, shift and clamp to 0..1.0, then pick by mode
   logic signed [38:0] vsum;
   logic signed [26:0] v_sh;
   logic signed [15:0] mix_px;

   assign vsum = 39'(u_ff) + 39'(w_ff);
   assign v_sh = vsum[38:12];

   always_comb begin
      if (v_sh < 27'sd0) mix_px = ZERO_PX;
      else if (v_sh > 27'(ONE_PX)) mix_px = ONE_PX;
      else mix_px = v_sh[15:0];
   end

   assign result = (mode == MODE_MIX) ? mix_px : oth4_ff;

endmodule
`default_nettype wire

// ----- rtl/rgb_point_color_ops.sv -----
`default_nettype none
`include "rgb_point_color_ops_defines.svh"
// Per-pixel RGB color operation on signed Q3.12 samples (4096 = 1.0): passthrough,
// invert, luminance threshold, sepia or channel mixer, chosen by filter_mode; modes
// 5 to 7 pass the pixel through. The datapath is five register stages (input, first
// products, shift and mode select, second products, output), and a pixel is registered
// in each of them in turn before it shows on rsp_valid. One pixel can be taken every
// clock while the output side is not stalled. Each stage holds its transaction while the
// next stage is full and stalled, so req_ready follows free space in the pipe, not the output side alone.
// The longest step is the 16 x 22 bit mixer multiply in the fourth stage. Write the
// csr registers only while no pixel is in flight.
module rgb_point_color_ops import rgbco_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]             csr_wr_data,
   // input pixels
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [15:0]      req_red_in,
   input  logic signed [15:0]      req_green_in,
   input  logic signed [15:0]      req_blue_in,
   input  logic                    req_row_end_in,
   // result pixels
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [15:0]      rsp_red_out,
   output logic signed [15:0]      rsp_green_out,
   output logic signed [15:0]      rsp_blue_out,
   output logic                    rsp_row_end_out
);

   // Configuration registers
   logic [2:0]         mode_ff;
   logic signed [15:0] thr_ff;
   logic signed [15:0] bg_bal_ff, into_r_ff, rb_bal_ff, into_g_ff, gr_bal_ff, into_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_PASS;
         thr_ff    <= THRESHOLD_RESET;
         bg_bal_ff <= '0;
         into_r_ff <= '0;
         rb_bal_ff <= '0;
         into_g_ff <= '0;
         gr_bal_ff <= '0;
         into_b_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FILTER_MODE:    mode_ff   <= csr_wr_data[2:0];
            CSR_THRESHOLD:      thr_ff    <= csr_wr_data;
            CSR_MIX_BG_BALANCE: bg_bal_ff <= csr_wr_data;
            CSR_MIX_INTO_RED:   into_r_ff <= csr_wr_data;
            CSR_MIX_RB_BALANCE: rb_bal_ff <= csr_wr_data;
            CSR_MIX_INTO_GREEN: into_g_ff <= csr_wr_data;
            CSR_MIX_GR_BALANCE: gr_bal_ff <= csr_wr_data;
            CSR_MIX_INTO_BLUE:  into_b_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Stage valid bits and the ready chain, output stage first
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   rgbco_load_type ld;

   assign rdy5 = !v5_ff || rsp_ready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_ready = rdy1;
   assign ld.s2 = rdy2;
   assign ld.s3 = rdy3;
   assign ld.s4 = rdy4;

   // Advance valid bits; a stalled stage holds its transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // Stage 1: input register
   logic signed [15:0] r1_ff, g1_ff, b1_ff;
   logic               e1_ff, e2_ff, e3_ff, e4_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         r1_ff <= req_red_in;
         g1_ff <= req_green_in;
         b1_ff <= req_blue_in;
         e1_ff <= req_row_end_in;
      end
   end

   // Threshold path: luminance sum, compare, then carry the decision
   logic signed [28:0] lum_in, lum2_ff;
   logic signed [16:0] lum_v;
   logic               white_in, white3_ff, white4_ff;

   assign lum_in   = 29'(LUM_R) * 29'(r1_ff) + 29'(LUM_G) * 29'(g1_ff)
                   + 29'(LUM_B) * 29'(b1_ff);
   assign lum_v    = lum2_ff[28:12];
   assign white_in = !(lum_v < 17'(thr_ff));

   always_ff @(posedge clock) begin
      if (rdy2) begin
         lum2_ff <= lum_in;
         e2_ff   <= e1_ff;
      end
      if (rdy3) begin
         white3_ff <= white_in;
         e3_ff     <= e2_ff;
      end
      if (rdy4) begin
         white4_ff <= white3_ff;
         e4_ff     <= e3_ff;
      end
   end

   // Channel lanes
   logic signed [15:0] red_res, green_res, blue_res;

   rgbco_lane u_lane_red (
      .clock   (clock),
      .ld      (ld),
      .mode    (mode_ff),
      .self_px (r1_ff),
      .p_px    (g1_ff),
      .q_px    (b1_ff),
      .k_self  (SEP_RR),
      .k_p     (SEP_RG),
      .k_q     (SEP_RB),
      .balance (bg_bal_ff),
      .amount  (into_r_ff),
      .result  (red_res)
   );

   rgbco_lane u_lane_green (
      .clock   (clock),
      .ld      (ld),
      .mode    (mode_ff),
      .self_px (g1_ff),
      .p_px    (b1_ff),
      .q_px    (r1_ff),
      .k_self  (SEP_GG),
      .k_p     (SEP_GB),
      .k_q     (SEP_GR),
      .balance (rb_bal_ff),
      .amount  (into_g_ff),
      .result  (green_res)
   );

   rgbco_lane u_lane_blue (
      .clock   (clock),
      .ld      (ld),
      .mode    (mode_ff),
      .self_px (b1_ff),
      .p_px    (r1_ff),
      .q_px    (g1_ff),
      .k_self  (SEP_BB),
      .k_p     (SEP_BR),
      .k_q     (SEP_BG),
      .balance (gr_bal_ff),
      .amount  (into_b_ff),
      .result  (blue_res)
   );

   // Stage 5: output register, threshold overrides all channels
   logic signed [15:0] thr_px;
   logic signed [15:0] red_in, green_in, blue_in;
   logic signed [15:0] red_ff, green_ff, blue_ff;
   logic               row_end_ff;

   assign thr_px   = white4_ff ? ONE_PX : ZERO_PX;
   assign red_in   = (mode_ff == MODE_THRESH) ? thr_px : red_res;
   assign green_in = (mode_ff == MODE_THRESH) ? thr_px : green_res;
   assign blue_in  = (mode_ff == MODE_THRESH) ? thr_px : blue_res;

   always_ff @(posedge clock) begin
      if (rdy5) begin
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
         row_end_ff <= e4_ff;
      end
   end

   assign rsp_valid       = v5_ff;
   assign rsp_red_out     = red_ff;
   assign rsp_green_out   = green_ff;
   assign rsp_blue_out    = blue_ff;
   assign rsp_row_end_out = row_end_ff;

   // Checks
   `RGBCO_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_valid && req_ready, v1_ff)
   `RGBCO_ASSERT_NEXT(a_s4_stall_holds, clock, reset, v4_ff && !rdy4, v4_ff)
   `RGBCO_ASSERT_NEXT(a_no_phantom_rsp, clock, reset, rsp_valid && rsp_ready && !v4_ff, !rsp_valid)

endmodule
`default_nettype wire

// ----- tb/rgb_point_color_ops_checker.sv -----
// Watches the csr port and both pixel channels, keeps its own copy of the
// register file and predicts every result pixel from the accepted input pixel.
module rgb_point_color_ops_checker import rgbco_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]             csr_wr_data,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic signed [15:0]      req_red_in,
   input  logic signed [15:0]      req_green_in,
   input  logic signed [15:0]      req_blue_in,
   input  logic                    req_row_end_in,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [15:0]      rsp_red_out,
   input  logic signed [15:0]      rsp_green_out,
   input  logic signed [15:0]      rsp_blue_out,
   input  logic                    rsp_row_end_out,
   output int unsigned             outstanding,
   output int unsigned             fail_count
);

   typedef struct packed {
      logic signed [15:0] red;
      logic signed [15:0] green;
      logic signed [15:0] blue;
      logic               row_end;
   } pixel_type;

   localparam longint UNITY     = ONE_Q12;
   localparam int     MAX_SHOWN = 10;

   // Mirror of the register file; mixer arrays are indexed red, green, blue
   logic [2:0]         mode_q;
   logic signed [15:0] level_q;
   logic signed [15:0] balance_q [3];
   logic signed [15:0] amount_q [3];

   pixel_type   expected_pixels [$];
   int unsigned faults;

   // Floor division by 4096
   function automatic longint floor_q12(input longint v);
      return v >>> 12;
   endfunction

   function automatic logic signed [15:0] sat16(input longint v);
      if (v > longint'(PX_MAX)) return PX_MAX;
      if (v < longint'(PX_MIN)) return PX_MIN;
      return v[15:0];
   endfunction

   // One row of the sepia matrix, capped at unity from above
   function automatic longint sepia_row(input longint r, input longint g, input longint b,
                                        input logic signed [12:0] kr,
                                        input logic signed [12:0] kg,
                                        input logic signed [12:0] kb);
      longint t;
      t = floor_q12(longint'(kr) * r + longint'(kg) * g + longint'(kb) * b);
      return (t > UNITY) ? UNITY : t;
   endfunction

   // Blend self with a balance-weighted mix of the other two, clamp to 0..unity
   function automatic longint mix_channel(input longint self_c, input longint p,
                                          input longint q,
                                          input logic signed [15:0] balance,
                                          input logic signed [15:0] amount);
      longint m;
      longint v;
      m = floor_q12(longint'(balance) * p + (UNITY - longint'(balance)) * q);
      v = floor_q12(longint'(amount) * m + (UNITY - longint'(amount)) * self_c);
      if (v < 0) return 0;
      if (v > UNITY) return UNITY;
      return v;
   endfunction

   function automatic pixel_type color_op(input pixel_type px);
      longint r, g, b, ro, go, bo, lum;
      pixel_type res;
      r  = longint'($signed(px.red));
      g  = longint'($signed(px.green));
      b  = longint'($signed(px.blue));
      ro = r;
      go = g;
      bo = b;
      case (mode_q)
         MODE_INVERT: begin
            ro = UNITY - r;
            go = UNITY - g;
            bo = UNITY - b;
         end
         MODE_THRESH: begin
            lum = floor_q12(longint'(LUM_R) * r + longint'(LUM_G) * g + longint'(LUM_B) * b);
            ro  = (lum < longint'(level_q)) ? 0 : UNITY;
            go  = ro;
            bo  = ro;
         end
         MODE_SEPIA: begin
            ro = sepia_row(r, g, b, SEP_RR, SEP_RG, SEP_RB);
            go = sepia_row(r, g, b, SEP_GR, SEP_GG, SEP_GB);
            bo = sepia_row(r, g, b, SEP_BR, SEP_BG, SEP_BB);
         end
         MODE_MIX: begin
            ro = mix_channel(r, g, b, balance_q[0], amount_q[0]);
            go = mix_channel(g, b, r, balance_q[1], amount_q[1]);
            bo = mix_channel(b, r, g, balance_q[2], amount_q[2]);
         end
         // spare codes pass the pixel through
         default: ;
      endcase
      res.red     = sat16(ro);
      res.green   = sat16(go);
      res.blue    = sat16(bo);
      res.row_end = px.row_end;
      return res;
   endfunction

   // Check results, queue predictions, track register writes
   always @(posedge clock) begin
      pixel_type got;
      pixel_type want;
      if (reset) begin
         mode_q  = MODE_PASS;
         level_q = THRESHOLD_RESET;
         foreach (balance_q[i]) begin
            balance_q[i] = ZERO_PX;
            amount_q[i]  = ZERO_PX;
         end
         expected_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = pixel_type'{rsp_red_out, rsp_green_out, rsp_blue_out, rsp_row_end_out};
            if (expected_pixels.size() == 0) begin
               faults++;
               if (faults <= MAX_SHOWN)
                  $display("checker: unexpected result r=%0d g=%0d b=%0d end=%0b",
                           got.red, got.green, got.blue, got.row_end);
            end else begin
               want = expected_pixels.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.row_end !== want.row_end) begin
                  faults++;
                  if (faults <= MAX_SHOWN)
                     $display("checker: mismatch mode=%0d expected r=%0d g=%0d b=%0d",
                              mode_q, want.red, want.green, want.blue,
                              " end=%0b, got r=%0d g=%0d b=%0d end=%0b", want.row_end,
                              got.red, got.green, got.blue, got.row_end);
               end
            end
         end
         if (req_valid && req_ready)
            expected_pixels.push_back(color_op(pixel_type'{req_red_in, req_green_in,
                                                          req_blue_in, req_row_end_in}));
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FILTER_MODE:    mode_q      = csr_wr_data[2:0];
               CSR_THRESHOLD:      level_q     = csr_wr_data;
               CSR_MIX_BG_BALANCE: balance_q[0] = csr_wr_data;
               CSR_MIX_INTO_RED:   amount_q[0]  = csr_wr_data;
               CSR_MIX_RB_BALANCE: balance_q[1] = csr_wr_data;
               CSR_MIX_INTO_GREEN: amount_q[1]  = csr_wr_data;
               CSR_MIX_GR_BALANCE: balance_q[2] = csr_wr_data;
               CSR_MIX_INTO_BLUE:  amount_q[2]  = csr_wr_data;
               // writes past the last register are dropped
               default: ;
            endcase
         end
      end
      outstanding <= expected_pixels.size();
      fail_count  <= faults;
   end

endmodule

// ----- tb/tb_rgb_point_color_ops.sv -----
module tb_rgb_point_color_ops;
   import rgbco_pkg::*;

   localparam int          REG_COUNT      = int'(CSR_MIX_INTO_BLUE) + 1;
   localparam logic [2:0]  MODE_SPARE_TOP = 3'd7;
   localparam int          CYCLE_LIMIT    = 200000;
   localparam int          SETTLE_CYCLES  = 8;
   localparam int          PHASES         = 16;
   localparam int          PHASE_PIXELS   = 50;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [15:0]             csr_wr_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [15:0]      req_red_in = '0;
   logic signed [15:0]      req_green_in = '0;
   logic signed [15:0]      req_blue_in = '0;
   logic                    req_row_end_in = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [15:0]      rsp_red_out;
   logic signed [15:0]      rsp_green_out;
   logic signed [15:0]      rsp_blue_out;
   logic                    rsp_row_end_out;

   int unsigned outstanding;
   int unsigned fail_count;
   int unsigned cycle_count = 0;
   int unsigned sender_idle = 0;
   int unsigned stall_pct = 0;

   // Idle patterns: none, sender, receiver, both
   int unsigned idle_table [4]  = '{0, 60, 0, 23};
   int unsigned stall_table [4] = '{0, 0, 60, 23};

   rgb_point_color_ops u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_row_end_in  (req_row_end_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_row_end_out (rsp_row_end_out)
   );

   rgb_point_color_ops_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_row_end_in  (req_row_end_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_row_end_out (rsp_row_end_out),
      .outstanding     (outstanding),
      .fail_count      (fail_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_rgb_point_color_ops: done, errors");
         $finish;
      end
   end

   // Sample or coefficient: mostly near 0..unity, some full range, some extremes
   function automatic logic [15:0] pick_value();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: begin
            case ($urandom_range(4))
               0:       return PX_MAX;
               1:       return PX_MIN;
               2:       return ZERO_PX;
               3:       return ONE_PX;
               default: return -16'sd1;
            endcase
         end
         default: return 16'($urandom_range(6144) - 1024);
      endcase
   endfunction

   // Present one pixel, optionally after an idle gap, and hold until accepted
   task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                             input logic [15:0] b, input logic row_end);
      if ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle);
      end
      req_valid      <= 1'b1;
      req_red_in     <= r;
      req_green_in   <= g;
      req_blue_in    <= b;
      req_row_end_in <= row_end;
      do @(posedge clock); while (!req_ready);
   endtask

   // Caller lowers csr_wr_en after the last write of a group
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   task automatic apply_config(input logic [2:0] mode, input logic [15:0] level,
                               input logic [15:0] bg, input logic [15:0] into_r,
                               input logic [15:0] rb, input logic [15:0] into_g,
                               input logic [15:0] gr, input logic [15:0] into_b);
      logic [15:0] values [REG_COUNT];
      values[CSR_FILTER_MODE]    = {13'($urandom), mode};
      values[CSR_THRESHOLD]      = level;
      values[CSR_MIX_BG_BALANCE] = bg;
      values[CSR_MIX_INTO_RED]   = into_r;
      values[CSR_MIX_RB_BALANCE] = rb;
      values[CSR_MIX_INTO_GREEN] = into_g;
      values[CSR_MIX_GR_BALANCE] = gr;
      values[CSR_MIX_INTO_BLUE]  = into_b;
      for (int i = 0; i < REG_COUNT; i++)
         write_reg(CSR_INDEX_W'(i), values[i]);
      // stray write past the last register must be ignored
      write_reg(CSR_INDEX_W'($urandom_range(2 ** CSR_INDEX_W - 1, REG_COUNT)),
                16'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   // Drop valid and wait until every predicted pixel has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned slot;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: passthrough with extremes
      send_pixel(PX_MAX, PX_MIN, ZERO_PX, 1'b1);
      send_pixel(-16'sd1, ONE_PX, 16'sd1, 1'b0);

      // Threshold at its reset level, pixels just either side
      drain();
      write_reg(CSR_FILTER_MODE, {13'd0, MODE_THRESH});
      csr_wr_en <= 1'b0;
      send_pixel(16'sd2048, 16'sd2048, 16'sd2048, 1'b0);
      send_pixel(16'sd2047, 16'sd2047, 16'sd2047, 1'b1);

      // Invert: the most negative sample saturates at the top, then ordinary values
      drain();
      apply_config(MODE_INVERT, ZERO_PX, ZERO_PX, ZERO_PX, ZERO_PX, ZERO_PX, ZERO_PX,
                   ZERO_PX);
      send_pixel(PX_MIN, PX_MIN, PX_MIN, 1'b0);
      send_pixel(PX_MAX, ONE_PX, -16'sd1, 1'b1);

      // Threshold: luminance equal to the level, one below, most negative and most positive level
      drain();
      apply_config(MODE_THRESH, 16'sd4097, ZERO_PX, ZERO_PX, ZERO_PX, ZERO_PX, ZERO_PX,
                   ZERO_PX);
      send_pixel(ONE_PX, ONE_PX, ONE_PX, 1'b0);
      send_pixel(16'sd4095, ONE_PX, ONE_PX, 1'b0);
      drain();
      apply_config(MODE_THRESH, PX_MIN, ZERO_PX, ZERO_PX, ZERO_PX, ZERO_PX, ZERO_PX,
                   ZERO_PX);
      send_pixel(PX_MIN, PX_MIN, PX_MIN, 1'b1);
      drain();
      apply_config(MODE_THRESH, PX_MAX, ZERO_PX, ZERO_PX, ZERO_PX, ZERO_PX, ZERO_PX,
                   ZERO_PX);
      send_pixel(PX_MAX, PX_MAX, PX_MAX, 1'b0);

      // Sepia: cap at unity, saturate below, one ordinary pixel
      drain();
      apply_config(MODE_SEPIA, ZERO_PX, ZERO_PX, ZERO_PX, ZERO_PX, ZERO_PX, ZERO_PX,
                   ZERO_PX);
      send_pixel(PX_MAX, PX_MAX, PX_MAX, 1'b0);
      send_pixel(PX_MIN, PX_MIN, PX_MIN, 1'b1);
      send_pixel(16'sd1000, 16'sd2000, -16'sd500, 1'b0);

      // Mixer with extreme weights
      drain();
      apply_config(MODE_MIX, ZERO_PX, PX_MIN, PX_MAX, PX_MAX, PX_MIN, ONE_PX, 16'sd2048);
      send_pixel(PX_MAX, PX_MIN, ZERO_PX, 1'b0);
      send_pixel(PX_MIN, PX_MAX, ONE_PX, 1'b1);
      send_pixel(16'sd1000, 16'sd2000, 16'sd3000, 1'b0);

      // Spare mode code acts as passthrough
      drain();
      write_reg(CSR_FILTER_MODE, {13'd0, MODE_SPARE_TOP});
      csr_wr_en <= 1'b0;
      send_pixel(PX_MIN, 16'sd1234, PX_MAX, 1'b1);

      // Random phases: every mode code, every idle pattern
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         slot = (phase + phase / 8) % 4;
         sender_idle <= idle_table[slot];
         stall_pct   <= stall_table[slot];
         apply_config(3'(phase < 8 ? phase : phase % 5), pick_value(), pick_value(),
                      pick_value(), pick_value(), pick_value(), pick_value(), pick_value());
         repeat (PHASE_PIXELS)
            send_pixel(pick_value(), pick_value(), pick_value(), $urandom_range(7) == 0);
      end

      drain();
      if (fail_count == 0)
         $display("tb_rgb_point_color_ops: done, clean");
      else
         $display("tb_rgb_point_color_ops: done, errors");
      $finish;
   end

endmodule
